// ===== rtl/core/htlp_pkg.sv =====
// ----------------------------------------------------------------------------
// htlp_pkg: shared types and constants of the linear-probe hash table
// Opcodes, field widths, controller states and the command/status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package htlp_pkg;

  localparam int LOG2_SLOTS_DEF = 10;
  localparam int KEY_W          = 64;
  localparam int VALUE_W        = 32;
  localparam int OP_W           = 2;
  localparam int PROBE_STEP     = 13;

  localparam logic [KEY_W-1:0] EMPTY_KEY = {KEY_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER = 2'd0,
    OP_QUERY    = 2'd1,
    OP_ERASE    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;    // write empty marker at clear pointer
    logic accept;      // latch word, start probe at home slot
    logic probe_next;  // step probe by PROBE_STEP
    logic commit;      // probe ended, apply op
    logic out_load;    // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;    // clear pointer at last slot
    logic skip;        // incoming word needs no probe
    logic hit;         // probed slot holds the key
    logic empty;       // probed slot is empty
    logic probe_last;  // every slot has been probed
  } sts_t;

endpackage

// ===== rtl/core/htlp_if.sv =====
// ----------------------------------------------------------------------------
// htlp_if: valid/ready channels of the linear-probe hash table
// Request channel (op, key, value) and result channel (value, flags).
// ----------------------------------------------------------------------------
interface htlp_in_if;
  logic                                valid;
  logic                                ready;
  logic [htlp_pkg::OP_W-1:0]           op;
  logic [htlp_pkg::KEY_W-1:0]          key;
  logic signed [htlp_pkg::VALUE_W-1:0] value_in;

  modport source (output valid, op, key, value_in, input ready);
  modport sink   (input valid, op, key, value_in, output ready);
endinterface

interface htlp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [htlp_pkg::VALUE_W-1:0] value_out;
  logic                                was_new;
  logic                                load_warning;
  logic                                overflow;

  modport source (output valid, value_out, was_new, load_warning, overflow, input ready);
  modport sink   (input valid, value_out, was_new, load_warning, overflow, output ready);
endinterface

// ===== rtl/core/htlp_ram.sv =====
// ----------------------------------------------------------------------------
// htlp_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module htlp_ram #(
  parameter int WIDTH = htlp_pkg::VALUE_W,
  parameter int DEPTH = 2 ** htlp_pkg::LOG2_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/htlp_ctrl.sv =====
// ----------------------------------------------------------------------------
// htlp_ctrl: controller of the linear-probe hash table
// Sequences the clearing pass, word accept, probe loop and result handoff.
// ----------------------------------------------------------------------------
module htlp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  htlp_pkg::sts_t  sts,
  output htlp_pkg::cmd_t  cmd
);

  htlp_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= htlp_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      htlp_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = htlp_pkg::ST_IDLE;
        end
      end
      htlp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.skip ? htlp_pkg::ST_DONE : htlp_pkg::ST_CHECK;
        end
      end
      htlp_pkg::ST_CHECK: begin
        if (sts.hit || sts.empty || sts.probe_last) begin
          cmd.commit = 1'b1;
          state_nxt  = htlp_pkg::ST_DONE;
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      htlp_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = htlp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = htlp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  // result never overwrites a word still waiting at the output
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over pending output word");

  // probe only closes on a hit, an empty slot or a full sweep
  a_commit_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (sts.hit || sts.empty || sts.probe_last))
    else $error("commit without probe end");

  // no word enters during the clearing pass
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == htlp_pkg::ST_CLEAR) |-> !cmd.accept && !in_ready)
    else $error("word accepted during clear");

endmodule

// ===== rtl/core/htlp_dp.sv =====
// ----------------------------------------------------------------------------
// htlp_dp: datapath of the linear-probe hash table
// Home-slot fold, probe pointer, key/value RAMs, entry count and results.
// ----------------------------------------------------------------------------
module htlp_dp #(
  parameter int LOG2_SLOTS = htlp_pkg::LOG2_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  htlp_pkg::cmd_t                      cmd,
  output htlp_pkg::sts_t                      sts,
  input  logic [htlp_pkg::OP_W-1:0]           in_op,
  input  logic [htlp_pkg::KEY_W-1:0]          in_key,
  input  logic signed [htlp_pkg::VALUE_W-1:0] in_value,
  output logic signed [htlp_pkg::VALUE_W-1:0] out_value,
  output logic                                out_was_new,
  output logic                                out_load_warning,
  output logic                                out_overflow
);

  localparam int NUM_SLOTS = 2 ** LOG2_SLOTS;
  localparam int NCHUNK    = (htlp_pkg::KEY_W + LOG2_SLOTS - 1) / LOG2_SLOTS;
  localparam int PAD_W     = NCHUNK * LOG2_SLOTS;
  localparam logic [LOG2_SLOTS:0]   HALF_SLOTS = (LOG2_SLOTS+1)'(NUM_SLOTS / 2);
  localparam logic [LOG2_SLOTS:0]   FULL_SLOTS = (LOG2_SLOTS+1)'(NUM_SLOTS);
  localparam logic [LOG2_SLOTS-1:0] STEP       = LOG2_SLOTS'(htlp_pkg::PROBE_STEP);

  // latched word
  htlp_pkg::op_t                 op_r;
  logic [htlp_pkg::KEY_W-1:0]    key_r;
  logic signed [htlp_pkg::VALUE_W-1:0] val_r;

  // probe / clear pointers
  logic [LOG2_SLOTS-1:0] slot_r, slot_nxt;
  logic [LOG2_SLOTS-1:0] probe_n_r;
  logic [LOG2_SLOTS-1:0] clr_addr_r;

  // table state
  logic [LOG2_SLOTS:0] cnt_r, cnt_nxt;
  logic                halted_r, halted_nxt;

  // results
  logic signed [htlp_pkg::VALUE_W-1:0] res_value_r, res_value_nxt;
  logic                                res_new_r, res_new_nxt;
  logic signed [htlp_pkg::VALUE_W-1:0] out_value_r;
  logic                                out_new_r, out_warn_r, out_ovf_r;

  // RAM ports
  logic                          key_we, val_we;
  logic [LOG2_SLOTS-1:0]         key_waddr, raddr;
  logic [htlp_pkg::KEY_W-1:0]    key_wdata, rd_key;
  logic [htlp_pkg::VALUE_W-1:0]  rd_val;

  logic [PAD_W-1:0]      key_pad;
  logic [LOG2_SLOTS-1:0] home;
  logic                  op_known;

  // home slot: XOR of all LOG2_SLOTS-bit chunks, top chunk zero padded
  assign key_pad = PAD_W'(in_key);
  always_comb begin
    home = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      home ^= key_pad[i*LOG2_SLOTS +: LOG2_SLOTS];
    end
  end

  always_comb begin
    op_known = in_op inside {htlp_pkg::OP_REGISTER, htlp_pkg::OP_QUERY, htlp_pkg::OP_ERASE};
  end

  assign slot_nxt = cmd.accept ? home : slot_r + STEP;
  assign raddr    = slot_nxt;

  assign sts.clr_last   = &clr_addr_r;
  assign sts.skip       = halted_r || (in_key == htlp_pkg::EMPTY_KEY) || !op_known;
  assign sts.hit        = (rd_key == key_r);
  assign sts.empty      = (rd_key == htlp_pkg::EMPTY_KEY);
  assign sts.probe_last = &probe_n_r;

  // clear writes, result reset at accept, op application at probe end
  always_comb begin
    key_we        = 1'b0;
    key_waddr     = slot_r;
    key_wdata     = key_r;
    val_we        = 1'b0;
    cnt_nxt       = cnt_r;
    halted_nxt    = halted_r;
    res_value_nxt = res_value_r;
    res_new_nxt   = res_new_r;
    if (cmd.clr_step) begin
      key_we    = 1'b1;
      key_waddr = clr_addr_r;
      key_wdata = htlp_pkg::EMPTY_KEY;
    end else if (cmd.accept) begin
      res_value_nxt = '0;
      res_new_nxt   = 1'b0;
    end else if (cmd.commit) begin
      case (op_r)
        htlp_pkg::OP_REGISTER: begin
          if (sts.hit) begin
            val_we = 1'b1;
          end else if (sts.empty) begin
            cnt_nxt = cnt_r + 1'b1;
            if (cnt_nxt[LOG2_SLOTS]) begin
              halted_nxt = 1'b1;
            end else begin
              key_we      = 1'b1;
              val_we      = 1'b1;
              res_new_nxt = 1'b1;
            end
          end else begin
            halted_nxt = 1'b1;
          end
        end
        htlp_pkg::OP_QUERY: begin
          if (sts.hit) begin
            res_value_nxt = rd_val;
          end
        end
        htlp_pkg::OP_ERASE: begin
          if (sts.hit) begin
            key_we    = 1'b1;
            key_wdata = htlp_pkg::EMPTY_KEY;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      probe_n_r  <= '0;
      cnt_r      <= '0;
      halted_r   <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.accept) begin
        probe_n_r <= '0;
      end else if (cmd.probe_next) begin
        probe_n_r <= probe_n_r + 1'b1;
      end
      cnt_r    <= cnt_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= htlp_pkg::op_t'(in_op);
      key_r <= in_key;
      val_r <= in_value;
    end
    if (cmd.accept || cmd.probe_next) begin
      slot_r <= slot_nxt;
    end
    res_value_r <= res_value_nxt;
    res_new_r   <= res_new_nxt;
    if (cmd.out_load) begin
      out_value_r <= res_value_r;
      out_new_r   <= res_new_r;
      out_warn_r  <= (cnt_r > HALF_SLOTS);
      out_ovf_r   <= halted_r;
    end
  end

  assign out_value        = out_value_r;
  assign out_was_new      = out_new_r;
  assign out_load_warning = out_warn_r;
  assign out_overflow     = out_ovf_r;

  htlp_ram #(
    .WIDTH (htlp_pkg::KEY_W),
    .DEPTH (NUM_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (rd_key)
  );

  htlp_ram #(
    .WIDTH (htlp_pkg::VALUE_W),
    .DEPTH (NUM_SLOTS)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (slot_r),
    .wdata (val_r),
    .raddr (raddr),
    .rdata (rd_val)
  );

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt cleared without reset");

  // count stops at the table size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_SLOTS)
    else $error("entry count past table size");

endmodule

// ===== rtl/core/hash_table_linear_probe.sv =====
// ----------------------------------------------------------------------------
// hash_table_linear_probe: open-addressed hash table, linear probing
// 64-bit keys to signed 32-bit values, register / query / erase requests.
// ----------------------------------------------------------------------------
// Usage: after reset the block runs a clearing pass over all slots
// that writes the empty marker into every key slot; in_ch.ready stays low
// for that time. Each request word then goes through these steps (one
// key-RAM read per cycle, read data registered): accept and start the read
// at the home slot, compare slot by slot until a hit, an empty slot or a
// full sweep, then hand the result to the output register once it is free.
// Words that need no probe (halted table, all-ones key, unknown op) go
// straight from accept to the handoff. The output register decouples the
// sides: a new word is taken while the last result still waits. Every
// word gives exactly one result word.
// ----------------------------------------------------------------------------
module hash_table_linear_probe #(
  parameter int LOG2_SLOTS = htlp_pkg::LOG2_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  htlp_in_if.sink           in_ch,
  htlp_out_if.source        out_ch
);

  // command/status between controller and datapath
  htlp_pkg::cmd_t cmd;
  htlp_pkg::sts_t sts;

  // sequencer: clear pass, accept, probe loop, result handoff
  htlp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hash fold, probe pointer, key/value stores, count, halt, result regs
  htlp_dp #(
    .LOG2_SLOTS (LOG2_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_ch.op),
    .in_key           (in_ch.key),
    .in_value         (in_ch.value_in),
    .out_value        (out_ch.value_out),
    .out_was_new      (out_ch.was_new),
    .out_load_warning (out_ch.load_warning),
    .out_overflow     (out_ch.overflow)
  );

endmodule

// ===== bench/tb_hash_table_linear_probe.sv =====
// ----------------------------------------------------------------------------
// tb_hash_table_linear_probe: self-checking bench for the linear-probe table
// Drives register / query / erase words through the request channel and
// checks every result word against a shadow copy of the table kept here.
// Directed words first, then random traffic, then a fill to overflow and words into the halted block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hash_table_linear_probe;

  localparam int SLOT_BITS = htlp_pkg::LOG2_SLOTS_DEF;
  localparam int NUM_SLOTS = 1 << SLOT_BITS;
  localparam int KEY_W     = htlp_pkg::KEY_W;
  localparam int VALUE_W   = htlp_pkg::VALUE_W;
  localparam int OP_W      = htlp_pkg::OP_W;
  localparam logic [KEY_W-1:0] EMPTY_KEY = htlp_pkg::EMPTY_KEY;
  // op encoding the block must ignore
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
  // homes that random keys are steered to, to build long probe chains
  localparam int HOT_HOMES = 6;
  localparam int HOT_STRIDE = 171;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_CAP = 200;
  localparam longint RUN_LIMIT_NS = 64'd50_000_000;

  // one expected result word
  typedef struct packed {
    logic [VALUE_W-1:0] value_out;
    logic               was_new;
    logic               load_warning;
    logic               overflow;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  htlp_in_if  in_ch();
  htlp_out_if out_ch();

  hash_table_linear_probe #(.LOG2_SLOTS(SLOT_BITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the table state
  logic [KEY_W-1:0]   shadow_keys   [NUM_SLOTS];
  logic [VALUE_W-1:0] shadow_values [NUM_SLOTS];
  int                 shadow_count;
  bit                 shadow_halted;

  result_t          pending_results[$];  // results still owed by the block
  logic [KEY_W-1:0] known_keys[$];       // every key that went in as new
  int               failures = 0;
  int               reports = 0;
  bit               src_idle_on;
  bit               sink_idle_on;

  // --------------------------------------------------------------------------
  // Shadow table
  // --------------------------------------------------------------------------
  function automatic void shadow_clear();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      shadow_keys[i]   = EMPTY_KEY;
      shadow_values[i] = '0;
    end
    shadow_count  = 0;
    shadow_halted = 1'b0;
  endfunction

  // home slot: XOR of SLOT_BITS-wide chunks, low end first
  function automatic logic [SLOT_BITS-1:0] fold_key(input logic [KEY_W-1:0] key);
    logic [SLOT_BITS-1:0] acc;
    acc = '0;
    for (int i = 0; i < KEY_W; i += SLOT_BITS)
      acc ^= SLOT_BITS'(key >> i);
    return acc;
  endfunction

  // walk from home by PROBE_STEP until the key or an empty slot turns up
  function automatic bit probe_slot(input logic [KEY_W-1:0] key, output int slot,
                                    output bit hit);
    int e;
    e = int'(fold_key(key));
    for (int n = 0; n < NUM_SLOTS; n++) begin
      if (shadow_keys[e] == key) begin
        slot = e;
        hit  = 1'b1;
        return 1'b1;
      end
      if (shadow_keys[e] == EMPTY_KEY) begin
        slot = e;
        hit  = 1'b0;
        return 1'b1;
      end
      e = (e + htlp_pkg::PROBE_STEP) % NUM_SLOTS;
    end
    slot = 0;
    hit  = 1'b0;
    return 1'b0;
  endfunction

  // apply one request word to the shadow table, return the result it owes
  function automatic result_t table_step(input logic [OP_W-1:0] op,
                                         input logic [KEY_W-1:0] key,
                                         input logic [VALUE_W-1:0] val);
    result_t r;
    int      slot;
    bit      hit;
    bit      found;
    r = '0;
    // halted table and the empty-marker key leave everything untouched
    if (!shadow_halted && key != EMPTY_KEY) begin
      found = probe_slot(key, slot, hit);
      case (op)
        htlp_pkg::OP_REGISTER: begin
          if (!found) begin
            shadow_halted = 1'b1;
          end else if (hit) begin
            shadow_values[slot] = val;
          end else begin
            // a new key counts even when it tips the table over
            shadow_count++;
            if (shadow_count >= NUM_SLOTS) begin
              shadow_halted = 1'b1;
            end else begin
              shadow_keys[slot]   = key;
              shadow_values[slot] = val;
              r.was_new           = 1'b1;
            end
          end
        end
        htlp_pkg::OP_QUERY: begin
          if (found && hit) r.value_out = shadow_values[slot];
        end
        htlp_pkg::OP_ERASE: begin
          // no tombstone, count stays
          if (found && hit) shadow_keys[slot] = EMPTY_KEY;
        end
        default: ;
      endcase
    end
    r.load_warning = (shadow_count > NUM_SLOTS / 2);
    r.overflow     = shadow_halted;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  // mostly no gap, some short ones, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    do k = {$urandom, $urandom}; while (k == '0 || k == EMPTY_KEY);
    return k;
  endfunction

  // random key whose chunks fold to the given home slot
  function automatic logic [KEY_W-1:0] key_at_home(input logic [SLOT_BITS-1:0] home);
    logic [KEY_W-1:0] k;
    do begin
      k = {$urandom, $urandom};
      k[SLOT_BITS-1:0] = '0;
      k[SLOT_BITS-1:0] = fold_key(k) ^ home;
    end while (k == '0 || k == EMPTY_KEY);
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(input int known_pct);
    if (known_keys.size() != 0 && $urandom_range(0, 99) < known_pct)
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
    if ($urandom_range(0, 99) < 30)
      return key_at_home(SLOT_BITS'($urandom_range(0, HOT_HOMES - 1) * HOT_STRIDE));
    return random_key();
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic void shuffle_idling();
    src_idle_on  = ($urandom_range(0, 3) != 0);
    sink_idle_on = ($urandom_range(0, 3) != 0);
  endfunction

  // --------------------------------------------------------------------------
  // Request side: starts and ends at a falling edge, valid held across
  // back-to-back words
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [VALUE_W-1:0] val);
    int      gap;
    result_t r;
    gap = src_idle_on ? idle_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.key      <= key;
    in_ch.value_in <= val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // word taken at this edge
    r = table_step(op, key, val);
    pending_results.push_back(r);
    if (r.was_new) known_keys.push_back(key);
    @(negedge clk);
  endtask

  // hold off the sender until every owed result is back
  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // one random word; whatever percentage is left after noise, register
  // and erase goes to query
  task automatic send_random(input int reg_pct, input int erase_pct,
                             input int reg_known_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)
      send_word(OP_UNKNOWN, pick_key(50), random_value());
    else if (r < 4)
      send_word(OP_W'($urandom_range(0, 3)), EMPTY_KEY, random_value());
    else if (r < 4 + reg_pct)
      send_word(htlp_pkg::OP_REGISTER, pick_key(reg_known_pct), random_value());
    else if (r < 4 + reg_pct + erase_pct)
      send_word(htlp_pkg::OP_ERASE, pick_key(85), random_value());
    else
      send_word(htlp_pkg::OP_QUERY, pick_key(80), random_value());
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls on ready, check on every accepted word
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && sink_idle_on && $urandom_range(0, 3) == 0)
        stall_left = idle_len();
      out_ch.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      failures++;
      if (reports < REPORT_CAP) begin
        reports++;
        $display("%0t ns: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        failures++;
        if (reports < REPORT_CAP) begin
          reports++;
          $display("%0t ns: result word with none expected, expected nothing, actual 0x%h %b%b%b",
                   $time, out_ch.value_out, out_ch.was_new, out_ch.load_warning,
                   out_ch.overflow);
        end
      end else begin
        want = pending_results.pop_front();
        compare_field("value_out", want.value_out, out_ch.value_out);
        compare_field("was_new", want.was_new, out_ch.was_new);
        compare_field("load_warning", want.load_warning, out_ch.load_warning);
        compare_field("overflow", want.overflow, out_ch.overflow);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // key extremes, value extremes, update, zero value, miss, erase, ignored words
  task automatic test_basic_ops();
    logic [KEY_W-1:0] lo_key;
    logic [KEY_W-1:0] hi_key;
    lo_key = 64'd1;
    hi_key = ~64'd1;
    send_word(htlp_pkg::OP_REGISTER, lo_key, 32'h7FFF_FFFF);
    send_word(htlp_pkg::OP_REGISTER, hi_key, 32'h8000_0000);
    send_word(htlp_pkg::OP_QUERY, lo_key, '0);
    send_word(htlp_pkg::OP_QUERY, hi_key, 32'hFFFF_FFFF);      // value ignored on query
    send_word(htlp_pkg::OP_REGISTER, lo_key, '0);               // update to zero, not new
    send_word(htlp_pkg::OP_QUERY, lo_key, '0);                  // stored zero comes back
    send_word(htlp_pkg::OP_QUERY, 64'h0123_4567_89AB_CDEF, '0); // absent key
    send_word(htlp_pkg::OP_ERASE, hi_key, 32'h5A5A_5A5A);
    send_word(htlp_pkg::OP_QUERY, hi_key, '0);
    send_word(htlp_pkg::OP_ERASE, hi_key, '0);                  // absent: no effect
    send_word(htlp_pkg::OP_REGISTER, hi_key, 32'hFFFF_FFFF);    // back in as new
    // empty marker as key: ignored for every op
    send_word(htlp_pkg::OP_REGISTER, EMPTY_KEY, 32'd5);
    send_word(htlp_pkg::OP_QUERY, EMPTY_KEY, '0);
    send_word(htlp_pkg::OP_ERASE, EMPTY_KEY, '0);
    send_word(OP_UNKNOWN, lo_key, 32'd77);
    send_word(htlp_pkg::OP_QUERY, lo_key, '0);
  endtask

  // three keys on one home; erasing the head cuts the chain behind it
  task automatic test_probe_chain();
    logic [KEY_W-1:0]     key_a;
    logic [KEY_W-1:0]     key_b;
    logic [KEY_W-1:0]     key_c;
    logic [SLOT_BITS-1:0] home;
    home  = SLOT_BITS'($urandom);
    key_a = key_at_home(home);
    key_b = key_at_home(home);
    key_c = key_at_home(home);
    send_word(htlp_pkg::OP_REGISTER, key_a, random_value());
    send_word(htlp_pkg::OP_REGISTER, key_b, random_value());
    send_word(htlp_pkg::OP_REGISTER, key_c, random_value());
    send_word(htlp_pkg::OP_QUERY, key_c, '0);
    send_word(htlp_pkg::OP_ERASE, key_a, '0);
    send_word(htlp_pkg::OP_QUERY, key_b, '0);                // lost behind the hole
    send_word(htlp_pkg::OP_REGISTER, key_b, random_value()); // new again, count rises
    send_word(htlp_pkg::OP_QUERY, key_b, '0);
    send_word(htlp_pkg::OP_QUERY, key_c, '0);
  endtask

  // mixed traffic at low to moderate load, with one full drain halfway
  task automatic test_random_mix();
    for (int i = 0; i < 300; i++) begin
      if (i % 50 == 0) shuffle_idling();
      if (i == 150) wait_results_done();
      send_random(50, 15, 25);
    end
  endtask

  // mostly new keys until the count hits the table size
  task automatic test_fill_to_overflow();
    int n;
    n = 0;
    while (!shadow_halted) begin
      if (n % 80 == 0) shuffle_idling();
      send_random(92, 2, 4);
      n++;
    end
  endtask

  // halted block: every word ignored, overflow flagged
  task automatic test_halted_block();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    for (int i = 0; i < 12; i++)
      send_random(40, 25, 50);
    send_word(htlp_pkg::OP_REGISTER, random_key(), random_value());
    send_word(htlp_pkg::OP_QUERY, known_keys[0], '0);
    send_word(htlp_pkg::OP_ERASE, known_keys[0], '0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid    = 1'b0;
    in_ch.op       = htlp_pkg::OP_REGISTER;
    in_ch.key      = '0;
    in_ch.value_in = '0;
    rst_n          = 1'b0;
    src_idle_on    = 1'b1;
    sink_idle_on   = 1'b1;
    shadow_clear();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    // first word waits out the clearing pass on ready
    test_basic_ops();
    test_probe_chain();
    test_random_mix();
    wait_results_done();
    test_fill_to_overflow();
    test_halted_block();
    wait_results_done();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/htlp_pkg.sv
rtl/core/htlp_if.sv
rtl/core/htlp_ram.sv
rtl/core/htlp_ctrl.sv
rtl/core/htlp_dp.sv
rtl/core/hash_table_linear_probe.sv
bench/tb_hash_table_linear_probe.sv
